FILE: design/sem_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude block.
// Used by the controller, the datapath, the root unit, the top level and the bench.
// Depends on nothing.
package sem_pkg;

	// Size limits and the register values after reset.
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int RESET_WIDTH   = 640;
	localparam int RESET_HEIGHT  = 480;
	localparam int HEIGHT_LIMIT  = 4096;
	localparam int ROW_W         = 13;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam int WIDTH_REG_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Input item codes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Arithmetic widths.
	localparam int CH_W   = 8;
	localparam int GRAD_W = 11;
	localparam int SUM_W  = 21;
	localparam int ROOT_W = 11;
	localparam int NUM_CH = 3;
	localparam logic [CH_W-1:0] MAG_MAX = 8'd255;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic            op;
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic            last_of_image;
	} out_item_t;

	// Which neighbor rows and columns lie inside the image.
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} nb_mask_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     mem_rd;
		logic     advance;
		logic     grad_en;
		logic     sq_en;
		nb_mask_t mask;
	} dp_cmd_t;

	typedef logic signed [GRAD_W-1:0] grad_t;
	typedef logic [SUM_W-1:0]         sum_t;

endpackage

FILE: design/sem_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type is given at instantiation.
interface sem_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/sem_root.sv
// Iterative rounded square root, three channel lanes sharing one step counter.
// One result bit per cycle; the output is rounded to nearest and saturated at 255.
// Depends on sem_pkg.
module sem_root
	import sem_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  sum_t [NUM_CH-1:0]          sums,
	output logic                       done,
	output logic [NUM_CH-1:0][CH_W-1:0] mags
);

	localparam int CNT_W = $clog2(ROOT_W);
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 1;

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	// Step sequencing shared by all lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(ROOT_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		logic [RAD_W-1:0]  rad_q;
		logic [REM_W-1:0]  rem_q;
		logic [ROOT_W-1:0] root_q;
		logic [REM_W+1:0]  rem_next;
		logic [REM_W+1:0]  trial;
		logic [ROOT_W:0]   rounded;

		// Bring down two radicand bits and try the next root bit.
		assign rem_next = {rem_q, rad_q[RAD_W-1 -: 2]};
		assign trial    = (REM_W+2)'({root_q, 2'b01});

		always_ff @(posedge clk) begin
			if (start) begin
				rad_q  <= RAD_W'(sums[ch]);
				rem_q  <= '0;
				root_q <= '0;
			end else if (run_q) begin
				rad_q <= rad_q << 2;
				if (rem_next >= trial) begin
					rem_q  <= REM_W'(rem_next - trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= REM_W'(rem_next);
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
		end

		// Round up when the remainder exceeds the root, then saturate.
		assign rounded  = {1'b0, root_q} + (ROOT_W+1)'(REM_W'(root_q) < rem_q);
		assign mags[ch] = (rounded > (ROOT_W+1)'(MAG_MAX)) ? MAG_MAX : rounded[CH_W-1:0];
	end

endmodule

FILE: design/sem_dp.sv
// Datapath: two line stores, the 3x3 pixel window, gradients and squared sums.
// Sequenced entirely by the controller's command struct and column address.
// Depends on sem_pkg.
module sem_dp
	import sem_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int AW        = $clog2(MAX_WIDTH)
) (
	input  logic              clk,
	input  dp_cmd_t           cmd,
	input  logic [AW-1:0]     addr,
	input  in_item_t          item,
	output sum_t [NUM_CH-1:0] sums
);

	rgb_t line_a [MAX_WIDTH];
	rgb_t line_b [MAX_WIDTH];
	rgb_t rd_a_q;
	rgb_t rd_b_q;
	rgb_t pix_q;
	rgb_t win_q [3][3];

	// Line store read with the incoming pixel; written back in the cycle after.
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_a_q <= line_a[addr];
			rd_b_q <= line_b[addr];
			pix_q  <= (item.op == OP_FLUSH) ? '0 : {item.in_red, item.in_green, item.in_blue};
		end
		if (cmd.advance) begin
			line_a[addr] <= pix_q;
			line_b[addr] <= rd_a_q;
		end
	end

	// Window shifts left; the new column is two rows up, one row up and the new pixel.
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rd_b_q;
			win_q[1][2] <= rd_a_q;
			win_q[2][2] <= pix_q;
		end
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
		grad_t t [3][3];
		grad_t gx;
		grad_t gy;
		grad_t gx_q;
		grad_t gy_q;
		logic signed [2*GRAD_W-1:0] px;
		logic signed [2*GRAD_W-1:0] py;
		sum_t  sum_q;

		// Taps outside the image read as zero.
		always_comb begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if ((r == 0 && !cmd.mask.top) || (r == 2 && !cmd.mask.bottom) ||
					    (c == 0 && !cmd.mask.left) || (c == 2 && !cmd.mask.right)) begin
						t[r][c] = '0;
					end else begin
						t[r][c] = GRAD_W'(win_q[r][c][(NUM_CH-1-ch)*CH_W +: CH_W]);
					end
				end
			end
		end

		assign gx = (t[0][2] + (t[1][2] <<< 1) + t[2][2]) - (t[0][0] + (t[1][0] <<< 1) + t[2][0]);
		assign gy = (t[2][0] + (t[2][1] <<< 1) + t[2][2]) - (t[0][0] + (t[0][1] <<< 1) + t[0][2]);
		assign px = gx_q * gx_q;
		assign py = gy_q * gy_q;

		always_ff @(posedge clk) begin
			if (cmd.grad_en) begin
				gx_q <= gx;
				gy_q <= gy;
			end
			if (cmd.sq_en) begin
				sum_q <= SUM_W'(px) + SUM_W'(py);
			end
		end

		assign sums[ch] = sum_q;
	end

endmodule

FILE: design/sem_ctrl.sv
// Controller: image geometry registers, input and result position counters, and the
// state machine that sequences the datapath and the root unit for each item.
// Depends on sem_pkg.
module sem_ctrl
	import sem_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int AW        = $clog2(MAX_WIDTH),
	parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_op,
	output logic                  in_ready,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output dp_cmd_t               cmd,
	output logic [AW-1:0]         addr,
	output logic                  root_start,
	input  logic                  root_done,
	input  logic                  out_busy,
	output logic                  out_load,
	output logic                  out_last
);

	localparam int EW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
	localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
	localparam logic [WW-1:0] RESET_W = (RESET_WIDTH > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(RESET_WIDTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SHIFT = 3'd1;
	localparam logic [2:0] S_GRAD  = 3'd2;
	localparam logic [2:0] S_SQ    = 3'd3;
	localparam logic [2:0] S_START = 3'd4;
	localparam logic [2:0] S_ROOT  = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;
	localparam logic [2:0] S_PAD   = 3'd7;

	logic [2:0]       state_q;
	logic [WW-1:0]    w_q;
	logic [ROW_W-1:0] h_q;
	logic [AW-1:0]    in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [AW-1:0]    res_col_q;
	logic [ROW_W-1:0] res_row_q;
	logic             complete_q;
	logic             emit_q;
	logic             pad_q;

	logic             take;
	logic             work;
	logic             lead;
	logic             in_col_last;
	logic             res_col_last;
	logic             res_row_last;
	logic [EW-1:0]    wv;
	logic [WW-1:0]    w_eff;
	logic [ROW_W-1:0] h_eff;

	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid && in_ready;
	assign work     = take && (((in_op == OP_PIXEL) && !complete_q) ||
	                           ((in_op == OP_FLUSH) && complete_q));
	// A pixel yields a result once a full row and one pixel lie behind it.
	assign lead     = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));

	assign in_col_last  = (WW'(in_col_q) == w_q - 1'b1);
	assign res_col_last = (WW'(res_col_q) == w_q - 1'b1);
	assign res_row_last = (res_row_q == h_q - 1'b1);

	// Clamp written sizes into the supported range.
	assign wv    = EW'(cfg_data[WIDTH_REG_W-1:0]);
	assign w_eff = (wv == '0) ? WW'(1) : ((wv > MAX_W_E) ? WW'(MAX_WIDTH) : WW'(wv));
	assign h_eff = (cfg_data == '0) ? ROW_W'(1) :
	               ((cfg_data > CFG_DATA_W'(HEIGHT_LIMIT)) ? ROW_W'(HEIGHT_LIMIT) : cfg_data);

	// Command decode. The pad read lies in the row below a one-row image, so the
	// bottom window row it fills is always masked.
	always_comb begin
		cmd.mem_rd      = work || (state_q == S_PAD);
		cmd.advance     = (state_q == S_SHIFT);
		cmd.grad_en     = (state_q == S_GRAD);
		cmd.sq_en       = (state_q == S_SQ);
		cmd.mask.top    = (res_row_q != '0);
		cmd.mask.bottom = !res_row_last;
		cmd.mask.left   = (res_col_q != '0);
		cmd.mask.right  = !res_col_last;
	end

	assign addr       = in_col_q;
	assign root_start = (state_q == S_START);
	assign out_load   = (state_q == S_EMIT) && !out_busy;
	assign out_last   = res_row_last && res_col_last;

	// Sequencer and position bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			w_q        <= RESET_W;
			h_q        <= ROW_W'(RESET_HEIGHT);
			in_col_q   <= '0;
			in_row_q   <= '0;
			res_col_q  <= '0;
			res_row_q  <= '0;
			complete_q <= 1'b0;
			emit_q     <= 1'b0;
			pad_q      <= 1'b0;
		end else if (cfg_we) begin
			// A size write aborts the image in progress.
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:  w_q <= w_eff;
				REG_IMAGE_HEIGHT: h_q <= h_eff;
				default:          w_q <= w_q;
			endcase
			in_col_q   <= '0;
			in_row_q   <= '0;
			res_col_q  <= '0;
			res_row_q  <= '0;
			complete_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (work) begin
						emit_q  <= (in_op == OP_FLUSH) || lead;
						// In a one-row image the first flush must shift twice to
						// bring the first pixel to the window center.
						pad_q   <= (in_op == OP_FLUSH) && !lead;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (in_col_last) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + 1'b1;
						if (in_row_q + 1'b1 >= h_q) begin
							complete_q <= 1'b1;
						end
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
					if (pad_q) begin
						pad_q   <= 1'b0;
						state_q <= S_PAD;
					end else begin
						state_q <= emit_q ? S_GRAD : S_IDLE;
					end
				end
				S_PAD:   state_q <= S_SHIFT;
				S_GRAD:  state_q <= S_SQ;
				S_SQ:    state_q <= S_START;
				S_START: state_q <= S_ROOT;
				S_ROOT: begin
					if (root_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_busy) begin
						state_q <= S_IDLE;
						if (out_last) begin
							in_col_q   <= '0;
							in_row_q   <= '0;
							res_col_q  <= '0;
							res_row_q  <= '0;
							complete_q <= 1'b0;
						end else if (res_col_last) begin
							res_col_q <= '0;
							res_row_q <= res_row_q + 1'b1;
						end else begin
							res_col_q <= res_col_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/sobel_edge_magnitude_rgb.sv
// RGB Sobel edge magnitude, 3x3 window, zero outside the image, line stores of MAX_WIDTH.
// An item is taken only while idle, and the next only once it is done. An item that gives a
// result also passes the gradient and square registers and the 11-step shared square root
// unit, then waits for the output register. The first flush of a one-row image shifts twice.
// Results come one row plus one pixel behind the input.
// Reset (arst_n low, asynchronous) sets 640 x 480 and an empty image; line stores are
// not cleared, they are read only where written within the same image.
module sobel_edge_magnitude_rgb
	import sem_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sem_stream_if.sink            pix_in,
	sem_stream_if.source          res_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	dp_cmd_t                     cmd;
	logic [AW-1:0]               addr;
	sum_t [NUM_CH-1:0]           sums;
	logic [NUM_CH-1:0][CH_W-1:0] mags;
	logic                        root_start;
	logic                        root_done;
	logic                        out_busy;
	logic                        out_load;
	logic                        out_last;
	logic                        out_valid_q;
	out_item_t                   out_data_q;
	in_item_t                    item;

	assign item = pix_in.data;

	sem_ctrl #(.MAX_WIDTH(MAX_WIDTH), .AW(AW), .WW(WW)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pix_in.valid),
		.in_op      (item.op),
		.in_ready   (pix_in.ready),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.addr       (addr),
		.root_start (root_start),
		.root_done  (root_done),
		.out_busy   (out_busy),
		.out_load   (out_load),
		.out_last   (out_last)
	);

	sem_dp #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_dp (
		.clk  (clk),
		.cmd  (cmd),
		.addr (addr),
		.item (item),
		.sums (sums)
	);

	sem_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.sums   (sums),
		.done   (root_done),
		.mags   (mags)
	);

	// Output register; a new result may load in the cycle the old one transfers.
	assign out_busy = out_valid_q && !res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.out_red       <= mags[0];
			out_data_q.out_green     <= mags[1];
			out_data_q.out_blue      <= mags[2];
			out_data_q.last_of_image <= out_last;
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.data  = out_data_q;

endmodule

FILE: bench/tb.sv
// Self-checking bench for the RGB Sobel edge magnitude block: streams images of many sizes,
// predicts every result in the bench and compares it field by field as it leaves the block.
// Depends on sem_pkg, sem_stream_if and the sobel_edge_magnitude_rgb top level.
`timescale 1ns / 100ps

module tb;
	import sem_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	sem_stream_if #(.T(in_item_t))  pix_if ();
	sem_stream_if #(.T(out_item_t)) res_if ();

	sobel_edge_magnitude_rgb dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_if),
		.res_out  (res_if),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Stimulus waiting to be sent and magnitudes waiting to come out.
	in_item_t  pixel_q[$];
	out_item_t magnitude_q[$];
	int        errors;
	int        cycle_count;

	// Mirror of the block's image state.
	int        width_eff;
	int        height_eff;
	int        col_pos;
	int        row_pos;
	int        emitted;
	bit        input_done;
	bit [23:0] frame[int];

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// The size registers clamp when written; a write restarts the image.
	task automatic set_size_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		int v;
		begin
			@(negedge clk);
			cfg_we   <= 1'b1;
			cfg_idx  <= idx;
			cfg_data <= value[CFG_DATA_W-1:0];
			if (idx == REG_IMAGE_WIDTH) begin
				v = value & 'h7FF;
				width_eff = (v == 0) ? 1 : (v > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : v);
			end else begin
				v = value & 'h1FFF;
				height_eff = (v == 0) ? 1 : (v > HEIGHT_LIMIT ? HEIGHT_LIMIT : v);
			end
			col_pos    = 0;
			row_pos    = 0;
			emitted    = 0;
			input_done = 1'b0;
			@(negedge clk);
			cfg_we <= 1'b0;
		end
	endtask

	// Rounded square root of a sum of squares, saturated at full scale.
	function automatic logic [CH_W-1:0] round_root(input int s);
		int r;
		begin
			if (s >= 65281)
				return MAG_MAX;
			r = 0;
			while ((r + 1) * (r + 1) <= s)
				r++;
			if (s > r * r + r)
				r++;
			return r[CH_W-1:0];
		end
	endfunction

	// Sobel magnitudes of the three channels at linear position m, zeros outside.
	function automatic out_item_t edge_magnitude(input int m);
		int        gx[3];
		int        gy[3];
		int        mr;
		int        mc;
		int        rr;
		int        cc;
		int        v;
		bit [23:0] p;
		out_item_t res;
		begin
			mr = m / width_eff;
			mc = m % width_eff;
			for (int ch = 0; ch < 3; ch++) begin
				gx[ch] = 0;
				gy[ch] = 0;
			end
			for (int dr = 0; dr < 3; dr++)
				for (int dc = 0; dc < 3; dc++) begin
					rr = mr + dr - 1;
					cc = mc + dc - 1;
					if (rr >= 0 && rr < height_eff && cc >= 0 && cc < width_eff) begin
						p = frame[rr * width_eff + cc];
						for (int ch = 0; ch < 3; ch++) begin
							v = (p >> (16 - 8 * ch)) & 'hFF;
							gx[ch] += v * (dc - 1) * ((dr == 1) ? 2 : 1);
							gy[ch] += v * (dr - 1) * ((dc == 1) ? 2 : 1);
						end
					end
				end
			res.out_red       = round_root(gx[0] * gx[0] + gy[0] * gy[0]);
			res.out_green     = round_root(gx[1] * gx[1] + gy[1] * gy[1]);
			res.out_blue      = round_root(gx[2] * gx[2] + gy[2] * gy[2]);
			res.last_of_image = 1'b0;
			return res;
		end
	endfunction

	// Work out the result, if any, that one accepted item causes.
	task automatic predict_magnitude(input in_item_t it);
		int        n;
		int        m;
		int        total;
		out_item_t res;
		begin
			total = width_eff * height_eff;
			if (it.op == OP_PIXEL) begin
				if (input_done)
					return;
				n = row_pos * width_eff + col_pos;
				frame[n] = {it.in_red, it.in_green, it.in_blue};
				col_pos++;
				if (col_pos >= width_eff) begin
					col_pos = 0;
					row_pos++;
					if (row_pos >= height_eff) begin
						row_pos    = 0;
						input_done = 1'b1;
					end
				end
				if (n < width_eff + 1)
					return;
				m = n - width_eff - 1;
			end else begin
				if (!input_done || emitted >= total)
					return;
				m = emitted;
			end
			res = edge_magnitude(m);
			emitted = m + 1;
			if (m + 1 >= total) begin
				res.last_of_image = 1'b1;
				col_pos    = 0;
				row_pos    = 0;
				emitted    = 0;
				input_done = 1'b0;
			end
			magnitude_q.push_back(res);
		end
	endtask

	// Both sides stall at random 19 percent of the time, except in a long quiet stretch.
	function automatic bit stall_now();
		return (cycle_count < 3000 || cycle_count >= 9000) && ($urandom_range(99) < 19);
	endfunction

	// Input transfers feed the predictor; results are checked against the oldest expectation.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (pix_if.valid && pix_if.ready)
			predict_magnitude(pix_if.data);
		if (res_if.valid && res_if.ready) begin
			if (magnitude_q.size() == 0) begin
				$display("%0t: result with none expected, actual %p", $time, res_if.data);
				errors++;
			end else begin
				if (res_if.data.out_red !== magnitude_q[0].out_red) begin
					$display("%0t: out_red expected %0d actual %0d", $time,
						magnitude_q[0].out_red, res_if.data.out_red);
					errors++;
				end
				if (res_if.data.out_green !== magnitude_q[0].out_green) begin
					$display("%0t: out_green expected %0d actual %0d", $time,
						magnitude_q[0].out_green, res_if.data.out_green);
					errors++;
				end
				if (res_if.data.out_blue !== magnitude_q[0].out_blue) begin
					$display("%0t: out_blue expected %0d actual %0d", $time,
						magnitude_q[0].out_blue, res_if.data.out_blue);
					errors++;
				end
				if (res_if.data.last_of_image !== magnitude_q[0].last_of_image) begin
					$display("%0t: last_of_image expected %0d actual %0d", $time,
						magnitude_q[0].last_of_image, res_if.data.last_of_image);
					errors++;
				end
				void'(magnitude_q.pop_front());
			end
		end
	end

	// Driver: hold an item until its transfer, then offer the next one or idle.
	bit pix_taken;
	always @(posedge clk)
		pix_taken <= pix_if.valid && pix_if.ready;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!pix_if.valid || pix_taken) begin
				if (pixel_q.size() != 0 && !stall_now()) begin
					pix_if.valid <= 1'b1;
					pix_if.data  <= pixel_q.pop_front();
				end else begin
					pix_if.valid <= 1'b0;
				end
			end
			res_if.ready <= !stall_now();
		end
	end

	function automatic logic [CH_W-1:0] pick_level();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	task automatic queue_pixel(input logic [CH_W-1:0] r, g, b);
		in_item_t it;
		begin
			it.op = OP_PIXEL;
			it.in_red = r;
			it.in_green = g;
			it.in_blue = b;
			pixel_q.push_back(it);
		end
	endtask

	task automatic queue_flush();
		in_item_t it;
		begin
			it.op = OP_FLUSH;
			it.in_red = CH_W'($urandom_range(255));
			it.in_green = CH_W'($urandom_range(255));
			it.in_blue = CH_W'($urandom_range(255));
			pixel_q.push_back(it);
		end
	endtask

	// Let everything drain, then give the block time to settle before a register write.
	task automatic drain();
		begin
			wait (pixel_q.size() == 0 && !pix_if.valid && magnitude_q.size() == 0);
			repeat (40) @(negedge clk);
		end
	endtask

	// One whole image of random pixels, with stray items when noisy and flushes to push out the tail.
	task automatic stream_image(input int w_reg, input int h_reg, input bit noisy);
		int total;
		begin
			set_size_reg(REG_IMAGE_WIDTH, w_reg);
			set_size_reg(REG_IMAGE_HEIGHT, h_reg);
			total = width_eff * height_eff;
			if (noisy)
				queue_flush();
			for (int i = 0; i < total; i++) begin
				queue_pixel(pick_level(), pick_level(), pick_level());
				if (noisy && $urandom_range(19) == 0)
					queue_flush();
			end
			if (noisy)
				queue_pixel(pick_level(), pick_level(), pick_level());
			for (int i = 0; i < width_eff + 1; i++)
				queue_flush();
			if (noisy)
				queue_flush();
			drain();
		end
	endtask

	initial begin
		errors       = 0;
		cycle_count  = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = REG_IMAGE_WIDTH;
		cfg_data     = '0;
		pix_if.valid = 1'b0;
		pix_if.data  = '0;
		res_if.ready = 1'b0;
		width_eff    = RESET_WIDTH;
		height_eff   = RESET_HEIGHT;
		col_pos      = 0;
		row_pos      = 0;
		emitted      = 0;
		input_done   = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: a 3x3 image of extreme levels with stray flushes and a late pixel.
		set_size_reg(REG_IMAGE_WIDTH, 3);
		set_size_reg(REG_IMAGE_HEIGHT, 3);
		queue_flush();
		for (int i = 0; i < 9; i++)
			if (i % 2 == 0)
				queue_pixel(8'd255, 8'd0, 8'd255);
			else
				queue_pixel(8'd0, 8'd255, 8'd0);
		queue_pixel(8'd255, 8'd255, 8'd255);
		repeat (4) queue_flush();
		queue_flush();
		drain();

		// Size extremes, including zero sizes that clamp and single-row images.
		stream_image(0, 0, 1'b1);
		stream_image(1, 1, 1'b0);
		stream_image(2, 3, 1'b1);
		stream_image(4, 1, 1'b0);
		stream_image(1, 5, 1'b1);

		// An image cut short by a register write before any result.
		set_size_reg(REG_IMAGE_WIDTH, 5);
		set_size_reg(REG_IMAGE_HEIGHT, 4);
		repeat (4) queue_pixel(pick_level(), pick_level(), pick_level());
		drain();

		// Random small images, now and then a wider or taller one.
		for (int sent = 0; sent < 530; ) begin
			automatic int w = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(8, 1);
			automatic int h = ($urandom_range(9) == 0) ? $urandom_range(10, 1) : $urandom_range(6, 1);
			stream_image(w, h, $urandom_range(1));
			sent += w * h + w + 1;
		end

		if (errors == 0)
			$display("sobel_edge_magnitude_rgb: match");
		else
			$display("sobel_edge_magnitude_rgb: mismatch");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("sobel_edge_magnitude_rgb: mismatch");
		$finish;
	end

endmodule
